### rtl/core/mbe_pkg.sv
`timescale 1ns / 1ps

package mbe_pkg;

  // payload widths of the pixel and result channels
  localparam int PIX_W   = 12;
  localparam int COUNT_W = 16;
  localparam int SHADE_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SIZE_W     = 13;
  localparam int LIMIT_W    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_MAX_ITER     = 2'd2
  } cfg_reg_t;

  localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH  = 13'd600;
  localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT = 13'd600;
  localparam logic [LIMIT_W-1:0] RST_MAX_ITER     = 16'd50;

endpackage

### rtl/core/mbe_in_if.sv
`timescale 1ns / 1ps

interface mbe_in_if import mbe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

### rtl/core/mbe_out_if.sv
`timescale 1ns / 1ps

interface mbe_out_if import mbe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] escape_count;
  logic               escaped;
  logic [SHADE_W-1:0] shade;

  modport source (output valid, output escape_count, output escaped, output shade,
                  input ready);
  modport sink   (input valid, input escape_count, input escaped, input shade,
                  output ready);
endinterface

### rtl/core/mbe_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module mbe_div #(
  parameter int NUM_W = 44,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [DEN_W:0]   trial;
  logic             take;

  assign trial = {rem, acc[NUM_W-1]};
  assign take  = trial >= {1'b0, dvs};
  assign quo   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      acc <= {acc[NUM_W-2:0], take};
      rem <= take ? DEN_W'(trial - {1'b0, dvs}) : trial[DEN_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_load: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && cnt == CNT_W'(NUM_W))
    else $error("divider did not load its step count");
  a_finish: assert property (@(posedge clk) disable iff (rst)
    busy && !start && cnt == CNT_W'(1) |=> done && !busy)
    else $error("divider missed its done pulse");
`endif

endmodule

### rtl/core/mandelbrot_escape_time_pixel.sv
`timescale 1ns / 1ps
// flow: the divider scales x, then y; z then iterates through S_MUL_RR, S_MUL_II, S_MUL_RI and
//   S_CHECK until escape or the limit, and an escaping pixel divides once more for its shade;
//   DIV_W = max(COORD_BITS+FRAC_BITS, 32) (40 at defaults)
// throughput: one pixel at a time; the shared bit-serial divider and the one shared
//   multiplier, stepped by the sequencer through each z iteration, set the pace
// reset: synchronous active-high rst; registers return to 600 / 600 / 50, no result pending
module mandelbrot_escape_time_pixel import mbe_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int ITER_BITS  = 16,
  parameter int FRAC_BITS  = 28
) (
  input  logic                  clk,
  input  logic                  rst,
  mbe_in_if.sink                pix,
  mbe_out_if.source             res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Q3.FRAC_BITS word and the full product width
  localparam int W   = FRAC_BITS + 4;
  localparam int P_W = 2 * W;

  // shared divider serves both coordinate scalings and the shade fraction
  localparam int NUMC  = COORD_BITS + FRAC_BITS;
  localparam int NUMS  = COUNT_W + SHADE_W;
  localparam int DIV_W = (NUMC > NUMS) ? NUMC : NUMS;
  localparam int DEN_W = LIMIT_W;
  localparam int A_W   = DIV_W + 1;

  // iteration counter is never wider than the 16-bit limit register
  localparam int CNT_W = (ITER_BITS < LIMIT_W) ? ITER_BITS : LIMIT_W;
  localparam logic [LIMIT_W-1:0] CAP =
    (ITER_BITS >= LIMIT_W) ? {LIMIT_W{1'b1}} : LIMIT_W'((1 << ITER_BITS) - 1);

  localparam logic signed [P_W-1:0] FX_MAX_P = (P_W'(1) <<< (FRAC_BITS + 3)) - P_W'(1);
  localparam logic signed [P_W-1:0] FX_MIN_P = ~FX_MAX_P;
  localparam logic signed [W-1:0]   FX_MAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic [P_W-1:0]        LIMIT4   = P_W'(4) << (2 * FRAC_BITS);

  // axis offsets 1.5 and 0.5, and the quotient above which the axis saturates
  localparam logic [A_W-1:0] OFF_RE = A_W'(3) << (FRAC_BITS - 1);
  localparam logic [A_W-1:0] OFF_IM = A_W'(1) << (FRAC_BITS - 1);
  localparam logic [A_W-1:0] FX_MAX_A = (A_W'(1) << (FRAC_BITS + 3)) - A_W'(1);
  localparam logic [A_W-1:0] SAT_RE = FX_MAX_A + OFF_RE;
  localparam logic [A_W-1:0] SAT_IM = FX_MAX_A + OFF_IM;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_X,
    S_DIV_Y,
    S_MUL_RR,
    S_MUL_II,
    S_MUL_RI,
    S_CHECK,
    S_DIV_S,
    S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [SIZE_W-1:0]  image_width;
  logic [SIZE_W-1:0]  image_height;
  logic [LIMIT_W-1:0] max_iterations;

  // working registers
  logic [COORD_BITS-1:0]  coord_y;
  logic signed [W-1:0]    cr, ci, zr, zi;
  logic signed [P_W-1:0]  rr, ii, prod;
  logic [CNT_W-1:0]       n;
  logic                   esc;
  logic [SHADE_W-1:0]     shade;

  // output register
  logic               res_valid;
  logic [COUNT_W-1:0] res_count;
  logic               res_esc;
  logic [SHADE_W-1:0] res_shade;

  // divider hookup
  logic             div_start;
  logic [DIV_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;

  // combinational helpers
  logic [LIMIT_W-1:0]    lim16;
  logic [CNT_W-1:0]      lim;
  logic [SIZE_W-1:0]     width_eff, height_eff;
  logic [A_W-1:0]        quo_a;
  logic signed [W-1:0]   axis_re, axis_im;
  logic signed [W-1:0]   mul_a, mul_b;
  logic signed [P_W-1:0] mul_p;
  logic [P_W-1:0]        mag2;
  logic                  hit;
  logic signed [P_W-1:0] diff, ri2, cr_ext, ci_ext, nr_w, ni_w;

  function automatic logic signed [W-1:0] sat_fx(input logic signed [P_W-1:0] v);
    logic signed [W-1:0] r;
    if (v > FX_MAX_P) r = FX_MAX_P[W-1:0];
    else if (v < FX_MIN_P) r = FX_MIN_P[W-1:0];
    else r = v[W-1:0];
    return r;
  endfunction

  mbe_div #(
    .NUM_W (DIV_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // effective limit and divisors, a zero size acts as one
  assign lim16      = (max_iterations > CAP) ? CAP : max_iterations;
  assign lim        = CNT_W'(lim16);
  assign width_eff  = (image_width == '0) ? SIZE_W'(1) : image_width;
  assign height_eff = (image_height == '0) ? SIZE_W'(1) : image_height;

  // quotient minus offset; the quotient is never negative, so only the top saturates
  assign quo_a   = {1'b0, div_quo};
  assign axis_re = (quo_a > SAT_RE) ? FX_MAX_W : W'(quo_a - OFF_RE);
  assign axis_im = (quo_a > SAT_IM) ? FX_MAX_W : W'(quo_a - OFF_IM);

  // one shared multiplier, operands picked by the sequencer
  always_comb begin
    case (state)
      S_MUL_RR: begin
        mul_a = zr;
        mul_b = zr;
      end
      S_MUL_II: begin
        mul_a = zi;
        mul_b = zi;
      end
      S_MUL_RI: begin
        mul_a = zr;
        mul_b = zi;
      end
      default: begin
        mul_a = zr;
        mul_b = zr;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // escape test on the full products, then next z with floor rescale
  assign mag2   = P_W'(unsigned'(rr)) + P_W'(unsigned'(ii));
  assign hit    = mag2 >= LIMIT4;
  assign cr_ext = {{(P_W-W){cr[W-1]}}, cr};
  assign ci_ext = {{(P_W-W){ci[W-1]}}, ci};
  assign diff   = rr - ii;
  assign ri2    = prod <<< 1;
  assign nr_w   = (diff >>> FRAC_BITS) + cr_ext;
  assign ni_w   = (ri2 >>> FRAC_BITS) + ci_ext;

  assign pix.ready        = (state == S_IDLE);
  assign res.valid        = res_valid;
  assign res.escape_count = res_count;
  assign res.escaped      = res_esc;
  assign res.shade        = res_shade;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      res_valid      <= 1'b0;
      div_start      <= 1'b0;
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
      max_iterations <= RST_MAX_ITER;
    end else begin
      div_start <= 1'b0;
      prod      <= mul_p;

      // register writes, anything beyond the list is dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  image_width    <= cfg_data[SIZE_W-1:0];
          REG_IMAGE_HEIGHT: image_height   <= cfg_data[SIZE_W-1:0];
          REG_MAX_ITER:     max_iterations <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (res_valid && res.ready) res_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (pix.valid) begin
            coord_y   <= COORD_BITS'(pix.pixel_y);
            div_num   <= DIV_W'(COORD_BITS'(pix.pixel_x)) << FRAC_BITS;
            div_den   <= DEN_W'(width_eff);
            div_start <= 1'b1;
            state     <= S_DIV_X;
          end
        end
        S_DIV_X: begin
          if (div_done) begin
            cr        <= axis_re;
            div_num   <= DIV_W'(coord_y) << FRAC_BITS;
            div_den   <= DEN_W'(height_eff);
            div_start <= 1'b1;
            state     <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_done) begin
            ci    <= axis_im;
            zr    <= '0;
            zi    <= '0;
            n     <= '0;
            state <= S_MUL_RR;
          end
        end
        S_MUL_RR: state <= S_MUL_II;
        S_MUL_II: begin
          rr    <= prod;
          state <= S_MUL_RI;
        end
        S_MUL_RI: begin
          ii    <= prod;
          state <= S_CHECK;
        end
        S_CHECK: begin
          // prod holds zr*zi here
          if (hit || n >= lim) begin
            esc <= (n < lim);
            if (n < lim) begin
              div_num   <= DIV_W'(n) << SHADE_W;
              div_den   <= DEN_W'(lim);
              div_start <= 1'b1;
              state     <= S_DIV_S;
            end else begin
              shade <= '0;
              state <= S_OUT;
            end
          end else begin
            zr    <= sat_fx(nr_w);
            zi    <= sat_fx(ni_w);
            n     <= n + CNT_W'(1);
            state <= S_MUL_RR;
          end
        end
        S_DIV_S: begin
          if (div_done) begin
            shade <= SHADE_W'(div_quo);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // wait for the output register to free up
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            res_count <= COUNT_W'(n);
            res_esc   <= esc;
            res_shade <= shade;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.ready |=> !pix.ready)
    else $error("pixel taken while a pixel is in work");
  a_inside_no_shade: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.escaped |-> res.shade == '0)
    else $error("shade set for a point that did not escape");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> n <= lim)
    else $error("iteration count ran past the limit");
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_X || state == S_DIV_Y || state == S_DIV_S))
    else $error("divider finished outside a divide step");
`endif

endmodule
